[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ring queue checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is held low.
`define SPRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define SPRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/sprq_pkg.sv]
// ----------------------------------------------------------------------------
// sprq_pkg
// Types and fixed constants of the strict priority ring queues.
// ----------------------------------------------------------------------------
`default_nettype none

package sprq_pkg;

  localparam int PAYLOAD_W     = 32;  // tdata width on both sides
  localparam int IN_LEVEL_W    = 2;
  localparam int OUT_LEVEL_W   = 2;
  localparam int IN_USER_W     = 3;   // mode, level
  localparam int OUT_USER_W    = 4;   // status, served level
  localparam int SIZE_W        = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_SIZE_REGS = 4;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOT_SET = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Compare results of the shared pointer unit.
  typedef struct packed {
    logic same;       // a == b
    logic next_same;  // advance(a) == b
  } ptr_flags_t;

endpackage

`default_nettype wire

[rtl/core/sprq_ptr_unit.sv]
// ----------------------------------------------------------------------------
// sprq_ptr_unit
// Shared pointer unit: advance modulo ring size and compare with the peer.
// ----------------------------------------------------------------------------
`default_nettype none

module sprq_ptr_unit #(
  parameter int PTR_W = 4
) (
  input  logic [PTR_W-1:0]            ptr_a,
  input  logic [PTR_W-1:0]            ptr_b,
  input  logic [sprq_pkg::SIZE_W-1:0] ring_size,
  output logic [PTR_W-1:0]            ptr_adv,
  output sprq_pkg::ptr_flags_t        flags
);
  import sprq_pkg::*;

  localparam int CW = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 1;

  logic [CW-1:0] inc;
  logic          wrap;

  assign inc  = CW'(ptr_a) + CW'(1);
  assign wrap = (inc == CW'(ring_size));
  // Wrap to slot zero at the ring size.
  assign ptr_adv = wrap ? '0 : inc[PTR_W-1:0];

  assign flags.same      = (ptr_a == ptr_b);
  assign flags.next_same = (ptr_adv == ptr_b);

endmodule

`default_nettype wire

[rtl/core/sprq_slot_mem.sv]
// ----------------------------------------------------------------------------
// sprq_slot_mem
// Slot store: one port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sprq_slot_mem #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_WIDTH-1:0]    wr_data,
  output logic [DATA_WIDTH-1:0]    rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/strict_priority_ring_queues.sv]
// Sequence: an accepted item is evaluated in S_EVAL; an enqueue finishes there, while a
//   dequeue scans from level 0 and reads the served slot from the registered memory in S_READ;
//   with all rings empty it visits every level, one level per cycle through the shared pointer unit.
//   A new item is taken only in S_IDLE, once the last result has gone to the output register.
// Reset: synchronous active low; clears sizes, pointers, sequencer and output valid.
//   The slot memory is not cleared; only slots written since the last pointer clear are read.
// ----------------------------------------------------------------------------
// strict_priority_ring_queues
// Per-level ring buffers in one slot store, strict priority dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

module strict_priority_ring_queues #(
  parameter int LEVELS     = 4,
  parameter int MAX_SLOTS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sprq_pkg::PAYLOAD_W-1:0]     in_tdata,   // [31:0] payload
  input  logic [sprq_pkg::IN_USER_W-1:0]     in_tuser,   // [0] mode, [2:1] level
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sprq_pkg::PAYLOAD_W-1:0]     out_tdata,  // [31:0] out_payload
  output logic [sprq_pkg::OUT_USER_W-1:0]    out_tuser,  // [1:0] status, [3:2] served_level
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sprq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sprq_pkg::SIZE_W-1:0]        cfg_data
);
  import sprq_pkg::*;

  // Only the first four levels own a size register; the rest never exist.
  localparam int NL     = (LEVELS < NUM_SIZE_REGS) ? LEVELS : NUM_SIZE_REGS;
  localparam int LV_W   = (NL > 1) ? $clog2(NL) : 1;
  localparam int PTR_W  = $clog2(MAX_SLOTS);
  localparam int DEPTH  = NL * MAX_SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // wait for an item
    S_EVAL = 4'b0010,  // one level through the pointer unit
    S_READ = 4'b0100,  // slot data arrives from memory
    S_HOLD = 4'b1000   // result waits for the output register
  } state_t;

  state_t                state_r, state_nxt;
  logic                  mode_r;
  logic                  bad_lvl_r;
  logic [LV_W-1:0]       lvl_r, lvl_nxt;
  logic [PAYLOAD_W-1:0]  payload_r;

  logic [SIZE_W-1:0]     size_r [NL];
  logic [PTR_W-1:0]      rp_r   [NL];
  logic [PTR_W-1:0]      wp_r   [NL];

  status_t               res_status_r;
  logic [LV_W-1:0]       res_level_r;
  logic [PAYLOAD_W-1:0]  res_payload_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [OUT_LEVEL_W-1:0] out_level_r;
  logic [PAYLOAD_W-1:0]  out_payload_r;

  logic                  in_acc;
  logic                  out_free;
  logic [SIZE_W-1:0]     cur_size;
  logic [SIZE_W-1:0]     eff_size;
  logic                  size_zero;
  logic [PTR_W-1:0]      ptr_a, ptr_b, ptr_adv;
  ptr_flags_t            flags;
  logic [ADDR_W-1:0]     mem_addr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic                  mem_we, mem_re;
  logic                  wp_we, rp_we;

  logic                  fin_en;
  status_t               fin_status;
  logic [LV_W-1:0]       fin_level;
  logic [PAYLOAD_W-1:0]  fin_payload;
  logic                  out_load;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Size of the level under work, clamped to the slot budget.
  assign cur_size  = size_r[lvl_r];
  assign eff_size  = (int'(cur_size) > MAX_SLOTS) ? SIZE_W'(MAX_SLOTS) : cur_size;
  assign size_zero = (cur_size == '0);

  // Enqueue advances the write pointer against read; dequeue the reverse.
  assign ptr_a = (mode_r == MODE_ENQ) ? wp_r[lvl_r] : rp_r[lvl_r];
  assign ptr_b = (mode_r == MODE_ENQ) ? rp_r[lvl_r] : wp_r[lvl_r];

  sprq_ptr_unit #(
    .PTR_W (PTR_W)
  ) u_ptr (
    .ptr_a     (ptr_a),
    .ptr_b     (ptr_b),
    .ring_size (eff_size),
    .ptr_adv   (ptr_adv),
    .flags     (flags)
  );

  assign mem_addr = ADDR_W'(lvl_r) * ADDR_W'(MAX_SLOTS) + ADDR_W'(ptr_a);

  sprq_slot_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .rd_en   (mem_re),
    .addr    (mem_addr),
    .wr_data (DATA_WIDTH'(payload_r)),
    .rd_data (mem_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    lvl_nxt     = lvl_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wp_we       = 1'b0;
    rp_we       = 1'b0;
    fin_en      = 1'b0;
    fin_status  = ST_OK;
    fin_level   = '0;
    fin_payload = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (mode_r == MODE_ENQ) begin
          fin_en = 1'b1;
          if (bad_lvl_r || size_zero) begin
            fin_status = ST_NOT_SET;
          end else if (flags.next_same) begin
            fin_status = ST_FULL;
          end else begin
            mem_we = 1'b1;
            wp_we  = 1'b1;
          end
        end else begin
          if (!size_zero && !flags.same) begin
            // Serve this level: fetch the slot, advance read.
            mem_re    = 1'b1;
            rp_we     = 1'b1;
            state_nxt = S_READ;
          end else if (lvl_r == LV_W'(NL - 1)) begin
            fin_en     = 1'b1;
            fin_status = ST_EMPTY;
          end else begin
            lvl_nxt = lvl_r + LV_W'(1);
          end
        end
      end
      S_READ: begin
        fin_en      = 1'b1;
        fin_level   = lvl_r;
        fin_payload = PAYLOAD_W'(mem_rdata);
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (fin_en) begin
      state_nxt = out_free ? S_IDLE : S_HOLD;
    end
  end

  assign out_load = (fin_en || (state_r == S_HOLD)) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture and scan index
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r    <= in_tuser[0];
      payload_r <= in_tdata;
      bad_lvl_r <= (in_tuser[0] == MODE_ENQ) && (int'(in_tuser[2:1]) >= NL);
      if ((in_tuser[0] == MODE_DEQ) || (int'(in_tuser[2:1]) >= NL)) begin
        lvl_r <= '0;
      end else begin
        lvl_r <= LV_W'(in_tuser[2:1]);
      end
    end else begin
      lvl_r <= lvl_nxt;
    end
  end

  // Park the result while the output register is still occupied.
  always_ff @(posedge clk) begin
    if (fin_en && !out_free) begin
      res_status_r  <= fin_status;
      res_level_r   <= fin_level;
      res_payload_r <= fin_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == S_HOLD) begin
        out_status_r  <= res_status_r;
        out_level_r   <= OUT_LEVEL_W'(res_level_r);
        out_payload_r <= res_payload_r;
      end else begin
        out_status_r  <= fin_status;
        out_level_r   <= OUT_LEVEL_W'(fin_level);
        out_payload_r <= fin_payload;
      end
    end
  end

  // Sizes and pointers; a size write clears that level's ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NL; i++) begin
        size_r[i] <= '0;
        rp_r[i]   <= '0;
        wp_r[i]   <= '0;
      end
    end else begin
      if (wp_we) begin
        wp_r[lvl_r] <= ptr_adv;
      end
      if (rp_we) begin
        rp_r[lvl_r] <= ptr_adv;
      end
      if (cfg_valid && cfg_ready && (int'(cfg_index) < NL)) begin
        size_r[LV_W'(cfg_index)] <= cfg_data;
        rp_r[LV_W'(cfg_index)]   <= '0;
        wp_r[LV_W'(cfg_index)]   <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_payload_r;
  assign out_tuser  = {out_level_r, out_status_r};

endmodule

`default_nettype wire

[rtl/core/sprq_checker.sv]
// ----------------------------------------------------------------------------
// sprq_checker
// Port-level assertions for the strict priority ring queues.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sprq_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [sprq_pkg::PAYLOAD_W-1:0]     out_tdata,
  input logic [sprq_pkg::OUT_USER_W-1:0]    out_tuser
);
  import sprq_pkg::*;

  // Hold a stalled result.
  `SPRQ_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // Only a served dequeue carries a level and a word.
  `SPRQ_ASSERT(a_fail_zero, clk, rst_n, out_tvalid && (out_tuser[1:0] != ST_OK) |-> (out_tuser[3:2] == '0) && (out_tdata == '0), "failed item carries data")

  // Drop ready while an accepted item is at work.
  `SPRQ_ASSERT(a_busy, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "ready held after accept")

  // No result right after reset.
  `SPRQ_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind strict_priority_ring_queues sprq_checker u_sprq_checker (.*);

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the strict priority ring queues.
// A directed table walks not-set levels, full and empty rings, size clamping,
// ignored register indexes and ring clears on size writes. Random items then
// run in segments under fresh ring sizes. Every result is compared with an
// in-bench model of the rings, or with a typed-in outcome for fixed rows.
// ----------------------------------------------------------------------------

module tb;
  import sprq_pkg::*;

  localparam int LEVELS      = 4;
  localparam int SLOTS       = 16;
  localparam int SEGMENTS    = 6;
  localparam int SEG_ITEMS   = 80;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [SIZE_W-1:0] FIRST_SIZES [NUM_SIZE_REGS] = '{5'd16, 5'd3, 5'd2, 5'd17};

  typedef struct packed {
    status_t                  status;
    logic [OUT_LEVEL_W-1:0]   level;
    logic [PAYLOAD_W-1:0]     word;
  } outcome_t;

  typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_t;

  // One line of the directed table: an item, or a ring size write.
  typedef struct packed {
    row_kind_t                kind;
    logic                     mode;
    logic [IN_LEVEL_W-1:0]    level;
    logic [PAYLOAD_W-1:0]     word;
    logic                     fixed;     // compare against want, not the model
    outcome_t                 want;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [SIZE_W-1:0]        reg_val;
  } row_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // DUT ports; the ones the bench drives are known from time zero
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [PAYLOAD_W-1:0]    in_tdata = '0;    // [31:0] payload
  logic [IN_USER_W-1:0]    in_tuser = '0;    // [0] mode, [2:1] level
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [PAYLOAD_W-1:0]    out_tdata;        // [31:0] out_payload
  logic [OUT_USER_W-1:0]   out_tuser;        // [1:0] status, [3:2] served_level
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [SIZE_W-1:0]       cfg_data = '0;

  // Sideband that travels with the item on the input: typed-in expectation
  logic      tag_fixed = 1'b0;
  outcome_t  tag_want = '0;

  // Ring model state
  logic [SIZE_W-1:0]     size_reg [NUM_SIZE_REGS];
  int                    rd_ptr [LEVELS];
  int                    wr_ptr [LEVELS];
  logic [PAYLOAD_W-1:0]  slots [LEVELS*SLOTS];
  outcome_t              pending_outcomes [$];

  int           errors = 0;
  int           send_gap_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_requests = 0;
  int unsigned  cycle_count = 0;

  strict_priority_ring_queues #(
    .LEVELS(LEVELS),
    .MAX_SLOTS(SLOTS),
    .DATA_WIDTH(PAYLOAD_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // --------------------------------------------------------------------------
  // Ring model
  // --------------------------------------------------------------------------

  initial begin
    foreach (size_reg[i]) size_reg[i] = '0;
    foreach (rd_ptr[i]) begin
      rd_ptr[i] = 0;
      wr_ptr[i] = 0;
    end
  end

  // Effective slot count: zero means the level is off, anything past SLOTS clamps.
  function automatic int ring_cap(int lv);
    return (size_reg[lv] > SLOTS) ? SLOTS : int'(size_reg[lv]);
  endfunction

  // A size write takes the new size and empties that ring, even if unchanged.
  function automatic void set_ring_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    int k;
    k = int'(idx);
    if (k < NUM_SIZE_REGS) begin
      size_reg[k] = val;
      rd_ptr[k] = 0;
      wr_ptr[k] = 0;
    end
  endfunction

  // Apply one item to the rings and return the outcome it produces.
  function automatic outcome_t service_outcome(logic mode, logic [IN_LEVEL_W-1:0] lv,
                                               logic [PAYLOAD_W-1:0] w);
    outcome_t r;
    int cap;
    int nxt;
    r = '{status: ST_OK, level: '0, word: '0};
    if (mode == MODE_ENQ) begin
      cap = ring_cap(int'(lv));
      if (cap == 0) begin
        r.status = ST_NOT_SET;
      end else begin
        // one slot stays empty, so a ring of one is always full
        nxt = (wr_ptr[lv] + 1) % cap;
        if (nxt == rd_ptr[lv]) begin
          r.status = ST_FULL;
        end else begin
          slots[lv*SLOTS + wr_ptr[lv]] = w;
          wr_ptr[lv] = nxt;
        end
      end
    end else begin
      // serve the lowest configured level that holds data
      r.status = ST_EMPTY;
      for (int l = 0; l < LEVELS; l++) begin
        if (r.status == ST_EMPTY && ring_cap(l) != 0 && rd_ptr[l] != wr_ptr[l]) begin
          r.status = ST_OK;
          r.level = OUT_LEVEL_W'(l);
          r.word = slots[l*SLOTS + rd_ptr[l]];
          rd_ptr[l] = (rd_ptr[l] + 1) % ring_cap(l);
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: check results first, then track size writes and accepted items.
  // One process, so pushes and pops never race each other.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser[1:0]);
        got.level = out_tuser[3:2];
        got.word = out_tdata;
        if (pending_outcomes.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = pending_outcomes.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("served_level", 32'(want.level), 32'(got.level));
          check_field("out_payload", want.word, got.word);
        end
      end
      if (cfg_valid && cfg_ready)
        set_ring_size(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        // always run the model so its rings stay in step with the block
        want = service_outcome(in_tuser[0], in_tuser[2:1], in_tdata);
        if (tag_fixed)
          want = tag_want;
        pending_outcomes.push_back(want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stalls, plus a long hold-off whenever one is requested
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int served_holds;
    served_holds = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != served_holds) begin
        served_holds++;
        out_tready <= 1'b0;
        // hold off long enough for the block to back up into its input
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one item and hold it until accepted. Valid is not dropped on exit,
  // so back-to-back items keep it high.
  task automatic send_item(logic mode, logic [IN_LEVEL_W-1:0] lv, logic [PAYLOAD_W-1:0] w,
                           logic fixed, outcome_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= {lv, mode};
    tag_fixed <= fixed;
    tag_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Write one size register; only called while the block is idle.
  task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small rings so they fill and wrap often; sometimes off, one, full or clamped.
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd1;
      2, 3, 4, 5: return 5'($urandom_range(2, 5));
      6: return 5'd16;
      7: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [PAYLOAD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t item_row(logic mode, logic [IN_LEVEL_W-1:0] lv,
                                    logic [PAYLOAD_W-1:0] w);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.mode = mode;
    r.level = lv;
    r.word = w;
    return r;
  endfunction

  // Rows whose outcome is plain: level and payload are zero for all of them.
  function automatic row_t fixed_row(logic mode, logic [IN_LEVEL_W-1:0] lv,
                                     logic [PAYLOAD_W-1:0] w, status_t st);
    row_t r;
    r = item_row(mode, lv, w);
    r.fixed = 1'b1;
    r.want = '{status: st, level: '0, word: '0};
    return r;
  endfunction

  function automatic row_t size_row(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_SIZE;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    row_t plan [$];
    int   enq_pct;
    logic mode;

    // Nothing is set up after reset: every enqueue is refused, every dequeue empty.
    plan.push_back(fixed_row(MODE_ENQ, 2'd0, 32'h0000_0000, ST_NOT_SET));
    plan.push_back(fixed_row(MODE_DEQ, 2'd0, 32'h0000_0000, ST_EMPTY));
    plan.push_back(fixed_row(MODE_ENQ, 2'd3, 32'hFFFF_FFFF, ST_NOT_SET));
    // Ring of one, ring of two, clamped ring, level off, and two stray indexes.
    plan.push_back(size_row(3'd0, 5'd1));
    plan.push_back(size_row(3'd1, 5'd2));
    plan.push_back(size_row(3'd2, 5'd31));
    plan.push_back(size_row(3'd3, 5'd0));
    plan.push_back(size_row(3'd4, 5'd9));
    plan.push_back(size_row(3'd7, 5'd31));
    plan.push_back(fixed_row(MODE_ENQ, 2'd0, 32'h0000_0001, ST_FULL));
    plan.push_back(fixed_row(MODE_ENQ, 2'd3, 32'h0000_0002, ST_NOT_SET));
    plan.push_back(fixed_row(MODE_ENQ, 2'd1, 32'hFFFF_FFFF, ST_OK));
    plan.push_back(fixed_row(MODE_ENQ, 2'd1, 32'h1234_5678, ST_FULL));
    plan.push_back(item_row(MODE_ENQ, 2'd2, 32'h0000_0000));
    plan.push_back(item_row(MODE_ENQ, 2'd2, 32'hA5A5_A5A5));
    // Drain in priority order; level and payload fields of a dequeue are don't-care.
    plan.push_back(item_row(MODE_DEQ, 2'd0, 32'h0000_0000));
    plan.push_back(item_row(MODE_DEQ, 2'd3, 32'hFFFF_FFFF));
    plan.push_back(item_row(MODE_DEQ, 2'd0, 32'h0000_0000));
    plan.push_back(fixed_row(MODE_DEQ, 2'd2, 32'h5A5A_5A5A, ST_EMPTY));
    // Bring level 3 up; level 1 still wins when both hold data.
    plan.push_back(size_row(3'd3, 5'd2));
    plan.push_back(item_row(MODE_ENQ, 2'd3, 32'hDEAD_BEEF));
    plan.push_back(item_row(MODE_ENQ, 2'd1, 32'h0000_0001));
    plan.push_back(item_row(MODE_DEQ, 2'd0, 32'h0000_0000));
    plan.push_back(item_row(MODE_DEQ, 2'd0, 32'h0000_0000));
    // Rewriting the same size still empties the ring.
    plan.push_back(item_row(MODE_ENQ, 2'd1, 32'h8000_0000));
    plan.push_back(size_row(3'd1, 5'd2));
    plan.push_back(fixed_row(MODE_DEQ, 2'd0, 32'h0000_0000, ST_EMPTY));
    // Writing zero empties the ring and turns the level off.
    plan.push_back(item_row(MODE_ENQ, 2'd3, 32'h7FFF_FFFF));
    plan.push_back(size_row(3'd3, 5'd0));
    plan.push_back(fixed_row(MODE_DEQ, 2'd0, 32'h0000_0000, ST_EMPTY));
    plan.push_back(fixed_row(MODE_ENQ, 2'd3, 32'h0F0F_0F0F, ST_NOT_SET));
    // Largest ring and a clamped one.
    plan.push_back(size_row(3'd0, 5'd16));
    plan.push_back(size_row(3'd1, 5'd17));
    plan.push_back(item_row(MODE_ENQ, 2'd0, 32'hC3C3_C3C3));
    plan.push_back(item_row(MODE_DEQ, 2'd1, 32'h0000_0000));

    // Hold reset, then release it once for the whole run.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 22;
    recv_stall_pct = 71;

    // Walk the directed table; size writes wait for the block to go idle.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SIZE) begin
        wait_for_results();
        write_size(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].mode, plan[i].level, plan[i].word, plan[i].fixed, plan[i].want);
      end
    end

    // Random segments, each under its own ring sizes.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          send_gap_pct = 22;
          recv_stall_pct = 71;
        end
        1: begin
          send_gap_pct = 71;
          recv_stall_pct = 22;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase

      wait_for_results();
      for (int r = 0; r < NUM_SIZE_REGS; r++)
        write_size(CFG_IDX_W'(r), (seg == 0) ? FIRST_SIZES[r] : pick_size());
      // now and then poke an index past the register list
      if ($urandom_range(0, 1) == 1)
        write_size(CFG_IDX_W'($urandom_range(NUM_SIZE_REGS, 7)), 5'($urandom_range(0, 31)));

      for (int n = 0; n < SEG_ITEMS; n++) begin
        // swing between filling and draining so rings hit full, wrap and empty
        if (n % 12 == 0)
          enq_pct = $urandom_range(15, 85);
        // pause the sender until every result is back
        if (n == SEG_ITEMS / 2)
          wait_for_results();
        // long receiver hold-off while items keep coming
        if (seg == 4 && n == 10)
          hold_requests <= hold_requests + 1;
        mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
        send_item(mode, 2'($urandom_range(0, 3)), pick_word(), 1'b0, '0);
      end
    end

    // Drain, then leave room for any stray result to show up.
    wait_for_results();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
